>>> hw/rtl/setpoint_waveform_generator_defines.svh
// ----------------------------------------------------------------------------
// Setpoint waveform generator assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SETPOINT_WAVEFORM_GENERATOR_DEFINES_SVH
`define SETPOINT_WAVEFORM_GENERATOR_DEFINES_SVH

// same-cycle implication
`define SWG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swg: same-cycle check failed");

// next-cycle implication
`define SWG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swg: next-cycle check failed");

`endif

>>> hw/rtl/swg_pkg.sv
// ----------------------------------------------------------------------------
// Setpoint waveform generator package
// Constants, register indexes and mode codes.
// ----------------------------------------------------------------------------
package swg_pkg;

  localparam int unsigned INDEX_BITS_DEF = 32;
  localparam int unsigned PHASE_BITS_DEF = 16;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned AMP_W      = 16;
  localparam int unsigned DUTY_W     = 17;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY   = 2'd3;

  localparam logic [1:0] MODE_SINE   = 2'd1;
  localparam logic [1:0] MODE_SQUARE = 2'd2;

  // Q16 polynomial coefficients of the quarter-wave sine
  localparam logic [16:0] SIN_A = 17'd102943;
  localparam logic [16:0] SIN_B = 17'd42047;
  localparam logic [16:0] SIN_C = 17'd4640;

endpackage

>>> hw/rtl/setpoint_waveform_generator.sv
// ----------------------------------------------------------------------------
// Setpoint waveform generator
// Step, sine or square setpoint sample for each requested sample index.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid_i, in_ready_o, sample_index_i   | item in
//  out     | out_valid_o, out_ready_i, setpoint_value_o | item out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_wdata_i | register write
//
// One item per cycle while the output is not stalled; the bit-per-stage restoring
// divider computes index mod period and then the phase.
// Reset clears valid bits and the configuration registers; no clearing pass.
// A stalled output holds every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module setpoint_waveform_generator #(
  parameter int unsigned INDEX_BITS = swg_pkg::INDEX_BITS_DEF,
  parameter int unsigned PHASE_BITS = swg_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [swg_pkg::FIELD_W-1:0]     sample_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [swg_pkg::AMP_W-1:0] setpoint_value_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swg_pkg::CFG_ADDR_W-1:0]  cfg_index_i,
  input  logic [swg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import swg_pkg::*;

  localparam int unsigned N     = INDEX_BITS;
  localparam int unsigned PB    = PHASE_BITS;
  localparam int unsigned QBITS = PB - 2;
  localparam int unsigned S     = N + PB + 6;

  typedef struct packed {
    logic step;
    logic sq;
  } flags_t;

  // configuration
  logic [1:0]        mode_q;
  logic [AMP_W-1:0]  amp_q;
  logic [FIELD_W-1:0] period_q;
  logic [DUTY_W-1:0] duty_q;
  logic [N-1:0]      per;
  logic [N+16:0]     dp_q;

  assign cfg_ready_o = 1'b1;
  assign per = period_q[N-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      amp_q    <= '0;
      period_q <= '0;
      duty_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:   mode_q   <= cfg_wdata_i[1:0];
        REG_AMP:    amp_q    <= cfg_wdata_i[AMP_W-1:0];
        REG_PERIOD: period_q <= cfg_wdata_i[FIELD_W-1:0];
        REG_DUTY:   duty_q   <= cfg_wdata_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // duty * period tracks the configuration
  always_ff @(posedge clk_i) begin
    dp_q <= (N+17)'(duty_q) * (N+17)'(per);
  end

  // valid chain and global advance
  logic [S-1:0] v_q;
  logic         en;

  assign en          = !v_q[S-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[S-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[S-2:0], in_valid_i};
    end
  end

  // index mod period, one bit per stage
  logic [N-1:0] mrem_q [N];
  logic [N-1:0] midx_q [N];

  for (genvar k = 0; k < N; k++) begin : g_mod
    logic [N-1:0] rin;
    logic [N-1:0] iin;
    logic [N:0]   sh;
    logic         ge;
    if (k == 0) begin : g_first
      assign rin = '0;
      assign iin = sample_index_i[N-1:0];
    end else begin : g_rest
      assign rin = mrem_q[k-1];
      assign iin = midx_q[k-1];
    end
    assign sh = {rin, iin[N-1-k]};
    assign ge = sh >= {1'b0, per};
    always_ff @(posedge clk_i) begin
      if (en) begin
        mrem_q[k] <= ge ? N'(sh - {1'b0, per}) : sh[N-1:0];
        midx_q[k] <= iin;
      end
    end
  end

  // phase = (r << PB) / period, one bit per stage
  logic [N-1:0]  prem_q [PB];
  logic [PB-1:0] pph_q  [PB];
  flags_t        pfl_q  [PB];

  for (genvar j = 0; j < PB; j++) begin : g_ph
    logic [N-1:0]  rin;
    logic [PB-1:0] phin;
    flags_t        flin;
    logic [N:0]    sh;
    logic          ge;
    if (j == 0) begin : g_first
      assign rin       = mrem_q[N-1];
      assign phin      = '0;
      assign flin.step = midx_q[N-1] >= per;
      assign flin.sq   = {1'b0, mrem_q[N-1], 16'b0} < dp_q;
    end else begin : g_rest
      assign rin  = prem_q[j-1];
      assign phin = pph_q[j-1];
      assign flin = pfl_q[j-1];
    end
    assign sh = {rin, 1'b0};
    assign ge = sh >= {1'b0, per};
    always_ff @(posedge clk_i) begin
      if (en) begin
        prem_q[j] <= ge ? N'(sh - {1'b0, per}) : sh[N-1:0];
        pph_q[j]  <= {phin[PB-2:0], ge};
        pfl_q[j]  <= flin;
      end
    end
  end

  // quarter-wave position
  logic [PB-1:0]  ph;
  logic [1:0]     quad;
  logic [PB-2:0]  xq;
  logic [16:0]    x16;
  logic [33:0]    a_prod;

  assign ph   = pph_q[PB-1];
  assign quad = ph[PB-1:PB-2];
  assign xq   = quad[0] ? ((PB-1)'(1) << QBITS) - {1'b0, ph[QBITS-1:0]}
                        : {1'b0, ph[QBITS-1:0]};

  if (QBITS <= 16) begin : g_shl
    assign x16 = 17'(xq) << (16 - QBITS);
  end else begin : g_shr
    assign x16 = 17'(xq >> (QBITS - 16));
  end

  assign a_prod = 34'(x16) * 34'(x16);

  // polynomial stages
  logic [16:0] ax16_q, ax2_q, bx16_q, bx2_q, bt1_q, cx16_q, ct2_q, ds_q, emag_q;
  logic [1:0]  aq_q, bq_q, cq_q, dq_q, eq_q;
  flags_t      afl_q, bfl_q, cfl_q, dfl_q, efl_q;
  logic [33:0] b_prod, c_prod, d_prod, e_prod;
  logic [16:0] absamp;

  assign b_prod = 34'(ax2_q) * 34'(SIN_C);
  assign c_prod = 34'(bx2_q) * 34'(bt1_q);
  assign d_prod = 34'(cx16_q) * 34'(ct2_q);
  assign absamp = amp_q[AMP_W-1] ? 17'(-$signed({amp_q[AMP_W-1], amp_q}))
                                 : {1'b0, amp_q};
  assign e_prod = 34'(absamp) * 34'(ds_q) + 34'd32768;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax16_q <= x16;
      ax2_q  <= a_prod[32:16];
      aq_q   <= quad;
      afl_q  <= pfl_q[PB-1];

      bx16_q <= ax16_q;
      bx2_q  <= ax2_q;
      bt1_q  <= SIN_B - b_prod[32:16];
      bq_q   <= aq_q;
      bfl_q  <= afl_q;

      cx16_q <= bx16_q;
      ct2_q  <= SIN_A - c_prod[32:16];
      cq_q   <= bq_q;
      cfl_q  <= bfl_q;

      ds_q   <= d_prod[32:16];
      dq_q   <= cq_q;
      dfl_q  <= cfl_q;

      emag_q <= e_prod[32:16];
      eq_q   <= dq_q;
      efl_q  <= dfl_q;
    end
  end

  // sign, saturate and pick the waveform
  logic              neg;
  logic [AMP_W-1:0]  sine_val;
  logic [AMP_W-1:0]  res;
  logic              pzero;
  logic [AMP_W-1:0]  out_q;

  assign neg   = amp_q[AMP_W-1] ^ eq_q[1];
  assign pzero = per == '0;

  always_comb begin
    if (neg) begin
      sine_val = AMP_W'(-emag_q);
    end else if (emag_q[16:15] != 2'b00) begin
      sine_val = {1'b0, {(AMP_W-1){1'b1}}};
    end else begin
      sine_val = emag_q[AMP_W-1:0];
    end
    case (mode_q)
      MODE_SINE:   res = pzero ? '0 : sine_val;
      MODE_SQUARE: res = (pzero || !efl_q.sq) ? '0 : amp_q;
      default:     res = efl_q.step ? amp_q : '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign setpoint_value_o = $signed(out_q);

endmodule

>>> hw/rtl/swg_checker.sv
// ----------------------------------------------------------------------------
// Setpoint waveform generator checker
// Port-level checks on handshake and stall behavior.
// ----------------------------------------------------------------------------
`include "setpoint_waveform_generator_defines.svh"

module swg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [swg_pkg::FIELD_W-1:0]      sample_index_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [swg_pkg::AMP_W-1:0] setpoint_value_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o
);
  import swg_pkg::*;

  // hold a stalled result
  `SWG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(setpoint_value_o))
  // a waiting input item keeps its index
  `SWG_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(sample_index_i))
  // empty output stage always takes an item
  `SWG_ASSERT_IMPL(a_ready_free, !out_valid_o, in_ready_o)
  // a stalled output stalls the whole pipeline
  `SWG_ASSERT_IMPL(a_stall_back, out_valid_o && !out_ready_i, !in_ready_o)
  // configuration writes never wait
  `SWG_ASSERT_IMPL(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind setpoint_waveform_generator swg_checker u_swg_checker (.*);
